// File: src/ecrt_pkg.sv
// Shared constants, codes and types for the entropy credit reseed trigger.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ecrt_pkg;

   localparam int NUM_SOURCES = 8;
   localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int CNT_W       = $clog2(NUM_SOURCES + 1);
   localparam int NUM_POOLS   = 2;

   localparam int ACTION_W    = 2;
   localparam int SOURCE_W    = 4;
   localparam int BITS_W      = 8;
   localparam int FRAC_W      = 10;
   localparam int WHOLE_W     = 16;
   localparam int THRESH_W    = 16;
   localparam int NEED_W      = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACTION_W-1:0] ACT_HARVEST  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_EVALUATE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FORCE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_NEEDED    = 2'd2;

   localparam logic [THRESH_W-1:0] FAST_THRESHOLD_RESET = 16'd100;
   localparam logic [THRESH_W-1:0] SLOW_THRESHOLD_RESET = 16'd160;
   localparam logic [NEED_W-1:0]   SLOW_NEEDED_RESET    = 5'd2;

   typedef struct packed {
      logic [THRESH_W-1:0] fast_threshold;
      logic [THRESH_W-1:0] slow_threshold;
      logic [NEED_W-1:0]   slow_sources_needed;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage
`default_nettype wire

// File: src/ecrt_ifs.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on ecrt_pkg for field widths.
`default_nettype none
interface ecrt_req_if import ecrt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SOURCE_W-1:0] source_index;
   logic [BITS_W-1:0]   event_bits;
   logic [FRAC_W-1:0]   event_frac;

   modport source (output valid, action, source_index, event_bits, event_frac, input ready);
   modport sink   (input valid, action, source_index, event_bits, event_frac, output ready);
endinterface

interface ecrt_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic pool_used;
   logic reseed_fast;
   logic reseed_slow;
   logic saturated;

   modport source (output valid, accepted, pool_used, reseed_fast, reseed_slow, saturated,
                   input ready);
   modport sink   (input valid, accepted, pool_used, reseed_fast, reseed_slow, saturated,
                   output ready);
endinterface
`default_nettype wire

// File: src/entropy_credit_reseed_trigger.sv
// Entropy credit reseed trigger: two-pool credit bookkeeping with reseed decisions.
// Usage:
//   req_bus carries one item (action, source_index, event_bits, event_frac) with
//   valid/ready; rsp_bus returns exactly one result per item with valid/ready.
//   csr_we/csr_index/csr_wdata write fast_threshold (0), slow_threshold (1) and
//   slow_sources_needed (2); write only while no item is in flight.
// Timing:
//   An item is taken in its load step and then executed in the execute step,
//   which waits while an earlier result is still held on rsp_bus. The result is
//   registered and shown on rsp_bus after the execute step; a new item is not
//   taken until the previous one has executed. Evaluation compares all counters
//   of both pools in parallel in the execute step, so no further steps are needed.
// Reset:
//   Synchronous reset clears all credit counters, points the next harvest at the
//   fast pool and loads the register defaults 100, 160 and 2.
// Stall:
//   While a result waits on rsp_bus.ready, the next item is still taken but is
//   held in its execute step until the waiting result is taken.
// Depends on ecrt_pkg, ecrt_ifs, ecrt_csr, ecrt_ctrl and ecrt_dp.
`default_nettype none
module entropy_credit_reseed_trigger import ecrt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ecrt_req_if.sink                   req_bus,
   ecrt_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type cfg;
   cmd_type cmd;

   ecrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ecrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   ecrt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_action       (req_bus.action),
      .req_source_index (req_bus.source_index),
      .req_event_bits   (req_bus.event_bits),
      .req_event_frac   (req_bus.event_frac),
      .rsp_accepted     (rsp_bus.accepted),
      .rsp_pool_used    (rsp_bus.pool_used),
      .rsp_reseed_fast  (rsp_bus.reseed_fast),
      .rsp_reseed_slow  (rsp_bus.reseed_slow),
      .rsp_saturated    (rsp_bus.saturated)
   );
endmodule
`default_nettype wire

// File: src/ecrt_csr.sv
// Configuration registers: thresholds and slow-source count.
// Depends on ecrt_pkg.
`default_nettype none
module ecrt_csr import ecrt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FAST_THRESHOLD: cfg_in.fast_threshold      = csr_wdata;
            CSR_SLOW_THRESHOLD: cfg_in.slow_threshold      = csr_wdata;
            CSR_SLOW_NEEDED:    cfg_in.slow_sources_needed = csr_wdata[NEED_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_threshold      <= FAST_THRESHOLD_RESET;
         cfg_ff.slow_threshold      <= SLOW_THRESHOLD_RESET;
         cfg_ff.slow_sources_needed <= SLOW_NEEDED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// File: src/ecrt_ctrl.sv
// Controller: sequences load and execute of one item and owns the response valid.
// Depends on ecrt_pkg.
`default_nettype none
module ecrt_ctrl import ecrt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic fire;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = req_valid && req_ready;
      fire      = !rsp_valid_ff || rsp_ready;
      cmd.exec  = (state_ff == ST_EXEC) && fire;
      state_in  = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.load) state_in = ST_EXEC;
         ST_EXEC: if (fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: src/ecrt_dp.sv
// Datapath: item register, per-pool credit counters, over-threshold compare and
// result register. Depends on ecrt_pkg.
`default_nettype none
module ecrt_dp import ecrt_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire cfg_type             cfg,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [SOURCE_W-1:0] req_source_index,
   input  wire logic [BITS_W-1:0]   req_event_bits,
   input  wire logic [FRAC_W-1:0]   req_event_frac,
   output logic                     rsp_accepted,
   output logic                     rsp_pool_used,
   output logic                     rsp_reseed_fast,
   output logic                     rsp_reseed_slow,
   output logic                     rsp_saturated
);
   logic [ACTION_W-1:0] action_ff;
   logic [SOURCE_W-1:0] source_ff;
   logic [BITS_W-1:0]   bits_ff;
   logic [FRAC_W-1:0]   frac_ff;

   logic [WHOLE_W-1:0] whole_ff [NUM_POOLS][NUM_SOURCES];
   logic [FRAC_W-1:0]  fract_ff [NUM_POOLS][NUM_SOURCES];
   logic               next_pool_ff;

   logic accepted_ff, pool_used_ff, reseed_fast_ff, reseed_slow_ff, saturated_ff;

   logic [NUM_SOURCES-1:0] over_fast, over_slow;
   logic [CNT_W-1:0]       slow_cnt;
   logic                   slow_ok;
   logic                   harvest, clear_fast, clear_slow;
   logic [SRC_W-1:0]       idx;
   logic [FRAC_W:0]        fsum;
   logic [WHOLE_W:0]       wsum;
   logic [WHOLE_W-1:0]     wnew;

   always_comb begin
      slow_cnt = '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         over_fast[s] = whole_ff[0][s] > cfg.fast_threshold;
         over_slow[s] = whole_ff[1][s] > cfg.slow_threshold;
         slow_cnt     = slow_cnt + CNT_W'(over_slow[s]);
      end
      slow_ok    = NEED_W'(slow_cnt) >= cfg.slow_sources_needed;
      idx        = source_ff[SRC_W-1:0];
      harvest    = (action_ff == ACT_HARVEST) &&
                   ({1'b0, source_ff} < (SOURCE_W+1)'(NUM_SOURCES));
      clear_fast = cmd.exec && ((action_ff == ACT_EVALUATE) || (action_ff == ACT_FORCE));
      clear_slow = cmd.exec && (action_ff == ACT_EVALUATE) && slow_ok;
      fsum       = {1'b0, fract_ff[next_pool_ff][idx]} + {1'b0, frac_ff};
      wsum       = {1'b0, whole_ff[next_pool_ff][idx]} + (WHOLE_W+1)'(bits_ff)
                   + (WHOLE_W+1)'(fsum[FRAC_W]);
      wnew       = wsum[WHOLE_W] ? {WHOLE_W{1'b1}} : wsum[WHOLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         source_ff <= req_source_index;
         bits_ff   <= req_event_bits;
         frac_ff   <= req_event_frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pool_ff <= 1'b0;
         for (int p = 0; p < NUM_POOLS; p++) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
               whole_ff[p][s] <= '0;
               fract_ff[p][s] <= '0;
            end
         end
      end else begin
         if (cmd.exec && harvest) next_pool_ff <= !next_pool_ff;
         for (int s = 0; s < NUM_SOURCES; s++) begin
            if (cmd.exec && harvest && !next_pool_ff && idx == SRC_W'(s)) begin
               whole_ff[0][s] <= wnew;
               fract_ff[0][s] <= fsum[FRAC_W-1:0];
            end else if (clear_fast && over_fast[s]) begin
               whole_ff[0][s] <= '0;
               fract_ff[0][s] <= '0;
            end
            if (cmd.exec && harvest && next_pool_ff && idx == SRC_W'(s)) begin
               whole_ff[1][s] <= wnew;
               fract_ff[1][s] <= fsum[FRAC_W-1:0];
            end else if (clear_slow && over_slow[s]) begin
               whole_ff[1][s] <= '0;
               fract_ff[1][s] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         accepted_ff    <= harvest;
         pool_used_ff   <= harvest && next_pool_ff;
         saturated_ff   <= harvest && wsum[WHOLE_W];
         reseed_fast_ff <= (action_ff == ACT_FORCE) ||
                           ((action_ff == ACT_EVALUATE) && (|over_fast));
         reseed_slow_ff <= (action_ff == ACT_EVALUATE) && slow_ok;
      end
   end

   assign rsp_accepted    = accepted_ff;
   assign rsp_pool_used   = pool_used_ff;
   assign rsp_reseed_fast = reseed_fast_ff;
   assign rsp_reseed_slow = reseed_slow_ff;
   assign rsp_saturated   = saturated_ff;
endmodule
`default_nettype wire
